[rtl/core/nfd_pkg.sv]
// ----------------------------------------------------------------------------
// nfd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package nfd_pkg;

  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_START = 8'hFF;
  localparam logic [7:0] BYTE_TFI   = 8'hD5;
  localparam logic [7:0] MIN_LEN    = 8'd2;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_PRE0,
    PH_PRE1,
    PH_START,
    PH_LEN,
    PH_LCS,
    PH_ACKPOST,
    PH_TFI,
    PH_CODE,
    PH_DATA,
    PH_DCS,
    PH_POST,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_ACK,
    KIND_NACK
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_ACK,
    ST_NACK,
    ST_PREAMBLE,
    ST_LENGTH,
    ST_DATA,
    ST_POST,
    ST_MISMATCH
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } res_t;

endpackage

[rtl/core/nfc_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// nfc_frame_deframer_unit
// Parses one controller read: preamble, length pair, ACK/NACK, direction byte,
// response code, payload, data checksum and postamble.
// ----------------------------------------------------------------------------
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   in_      | slave     | tdata = rx_byte, tuser = read_start
//   out_     | master    | tdata = data, tuser = status, tlast = last
//   cfg_     | write     | wr_data = expected_command
//
// One input beat can be taken every cycle while in_tready is high; its result,
// if any, shows on the out_ side in the next cycle when the output register is
// free. The rate is set by the single-cycle frame state machine. A two-entry
// output buffer parts the sides: in_tready drops only when both entries hold an
// untaken result. Reset is synchronous and active low; it clears the frame
// state, the expected command and the buffer valid bits.
// ----------------------------------------------------------------------------
module nfc_frame_deframer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,  // [7:0] expected_command
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [7:0] rx_byte
  input  logic       in_tuser,     // [0] read_start
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // [7:0] data
  output logic [2:0] out_tuser,    // [2:0] status
  output logic       out_tlast
);

  logic          beat;
  logic          res_valid;
  logic          space;
  nfd_pkg::res_t res;
  nfd_pkg::res_t out_res;

  // Advance the parser on every accepted input beat.
  assign in_tready = space;
  assign beat      = in_tvalid & in_tready;

  nfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .beat        (beat),
    .rx_byte     (in_tdata),
    .read_start  (in_tuser),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Hold results here until the downstream side takes them.
  nfd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (beat & res_valid),
    .push_res  (res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = out_res.status;
  assign out_tlast = out_res.last;

endmodule

[rtl/core/nfd_parser.sv]
// ----------------------------------------------------------------------------
// nfd_parser
// Frame state machine: checks each accepted byte and forms at most one result.
// ----------------------------------------------------------------------------
module nfd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          beat,
  input  logic [7:0]    rx_byte,
  input  logic          read_start,
  output logic          res_valid,
  output nfd_pkg::res_t res
);

  nfd_pkg::phase_t phase_r, phase_nxt;
  nfd_pkg::kind_t  frame_kind_r, frame_kind_nxt;
  logic [7:0]      frame_length_r, frame_length_nxt;
  logic [7:0]      data_sum_r, data_sum_nxt;
  logic [7:0]      bytes_left_r, bytes_left_nxt;
  logic [7:0]      expected_command_r;

  logic [7:0] sum_in;
  logic [7:0] payload_cnt;
  logic [7:0] resp_code;
  logic [7:0] len_check;

  assign sum_in      = data_sum_r + rx_byte;
  assign payload_cnt = frame_length_r - nfd_pkg::MIN_LEN;
  assign resp_code   = expected_command_r + 8'd1;
  assign len_check   = frame_length_r + rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_command_r <= '0;
    end else if (cfg_wr_en) begin
      expected_command_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= nfd_pkg::PH_IDLE;
      frame_kind_r   <= nfd_pkg::KIND_NORMAL;
      frame_length_r <= '0;
      data_sum_r     <= '0;
      bytes_left_r   <= '0;
    end else if (beat) begin
      phase_r        <= phase_nxt;
      frame_kind_r   <= frame_kind_nxt;
      frame_length_r <= frame_length_nxt;
      data_sum_r     <= data_sum_nxt;
      bytes_left_r   <= bytes_left_nxt;
    end
  end

  // Next state
  always_comb begin
    phase_nxt        = phase_r;
    frame_kind_nxt   = frame_kind_r;
    frame_length_nxt = frame_length_r;
    data_sum_nxt     = data_sum_r;
    bytes_left_nxt   = bytes_left_r;
    if (read_start) begin
      phase_nxt        = nfd_pkg::PH_PRE0;
      frame_kind_nxt   = nfd_pkg::KIND_NORMAL;
      frame_length_nxt = '0;
      data_sum_nxt     = '0;
      bytes_left_nxt   = '0;
    end else begin
      case (phase_r)
        nfd_pkg::PH_PRE0: begin
          phase_nxt = (rx_byte == nfd_pkg::BYTE_ZERO) ? nfd_pkg::PH_PRE1 : nfd_pkg::PH_DONE;
        end
        nfd_pkg::PH_PRE1: begin
          phase_nxt = (rx_byte == nfd_pkg::BYTE_ZERO) ? nfd_pkg::PH_START : nfd_pkg::PH_DONE;
        end
        nfd_pkg::PH_START: begin
          phase_nxt = (rx_byte == nfd_pkg::BYTE_START) ? nfd_pkg::PH_LEN : nfd_pkg::PH_DONE;
        end
        nfd_pkg::PH_LEN: begin
          frame_length_nxt = rx_byte;
          phase_nxt        = nfd_pkg::PH_LCS;
        end
        nfd_pkg::PH_LCS: begin
          if (frame_length_r == nfd_pkg::BYTE_ZERO && rx_byte == nfd_pkg::BYTE_START) begin
            frame_kind_nxt = nfd_pkg::KIND_ACK;
            phase_nxt      = nfd_pkg::PH_ACKPOST;
          end else if (frame_length_r == nfd_pkg::BYTE_START &&
                       rx_byte == nfd_pkg::BYTE_ZERO) begin
            frame_kind_nxt = nfd_pkg::KIND_NACK;
            phase_nxt      = nfd_pkg::PH_ACKPOST;
          end else if (len_check != '0 || frame_length_r < nfd_pkg::MIN_LEN) begin
            phase_nxt = nfd_pkg::PH_DONE;
          end else begin
            frame_kind_nxt = nfd_pkg::KIND_NORMAL;
            phase_nxt      = nfd_pkg::PH_TFI;
          end
        end
        nfd_pkg::PH_ACKPOST: begin
          phase_nxt = nfd_pkg::PH_DONE;
        end
        nfd_pkg::PH_TFI: begin
          if (rx_byte == nfd_pkg::BYTE_TFI) begin
            data_sum_nxt = rx_byte;
            phase_nxt    = nfd_pkg::PH_CODE;
          end else begin
            phase_nxt = nfd_pkg::PH_DONE;
          end
        end
        nfd_pkg::PH_CODE: begin
          if (rx_byte == resp_code) begin
            data_sum_nxt   = sum_in;
            bytes_left_nxt = payload_cnt;
            phase_nxt      = (payload_cnt == '0) ? nfd_pkg::PH_DCS : nfd_pkg::PH_DATA;
          end else begin
            phase_nxt = nfd_pkg::PH_DONE;
          end
        end
        nfd_pkg::PH_DATA: begin
          data_sum_nxt   = sum_in;
          bytes_left_nxt = bytes_left_r - 8'd1;
          if (bytes_left_r == 8'd1) begin
            phase_nxt = nfd_pkg::PH_DCS;
          end
        end
        nfd_pkg::PH_DCS: begin
          data_sum_nxt = sum_in;
          phase_nxt    = (sum_in == '0) ? nfd_pkg::PH_POST : nfd_pkg::PH_DONE;
        end
        nfd_pkg::PH_POST: begin
          phase_nxt = nfd_pkg::PH_DONE;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Result forming
  always_comb begin
    res_valid  = 1'b0;
    res.data   = '0;
    res.status = nfd_pkg::ST_OK;
    res.last   = 1'b1;
    if (!read_start) begin
      case (phase_r)
        nfd_pkg::PH_PRE0, nfd_pkg::PH_PRE1: begin
          res_valid  = (rx_byte != nfd_pkg::BYTE_ZERO);
          res.status = nfd_pkg::ST_PREAMBLE;
        end
        nfd_pkg::PH_START: begin
          res_valid  = (rx_byte != nfd_pkg::BYTE_START);
          res.status = nfd_pkg::ST_PREAMBLE;
        end
        nfd_pkg::PH_LCS: begin
          res_valid  = !(frame_length_r == nfd_pkg::BYTE_ZERO &&
                         rx_byte == nfd_pkg::BYTE_START) &&
                       !(frame_length_r == nfd_pkg::BYTE_START &&
                         rx_byte == nfd_pkg::BYTE_ZERO) &&
                       (len_check != '0 || frame_length_r < nfd_pkg::MIN_LEN);
          res.status = nfd_pkg::ST_LENGTH;
        end
        nfd_pkg::PH_ACKPOST: begin
          res_valid = 1'b1;
          if (rx_byte != nfd_pkg::BYTE_ZERO) begin
            res.status = nfd_pkg::ST_POST;
          end else if (frame_kind_r == nfd_pkg::KIND_ACK) begin
            res.status = nfd_pkg::ST_ACK;
          end else begin
            res.status = nfd_pkg::ST_NACK;
          end
        end
        nfd_pkg::PH_TFI: begin
          res_valid  = (rx_byte != nfd_pkg::BYTE_TFI);
          res.status = nfd_pkg::ST_MISMATCH;
        end
        nfd_pkg::PH_CODE: begin
          res_valid  = (rx_byte != resp_code);
          res.status = nfd_pkg::ST_MISMATCH;
        end
        nfd_pkg::PH_DATA: begin
          res_valid = 1'b1;
          res.data  = rx_byte;
          res.last  = 1'b0;
        end
        nfd_pkg::PH_DCS: begin
          res_valid  = (sum_in != '0);
          res.data   = payload_cnt;
          res.status = nfd_pkg::ST_DATA;
        end
        nfd_pkg::PH_POST: begin
          res_valid  = 1'b1;
          res.data   = payload_cnt;
          res.status = (rx_byte != nfd_pkg::BYTE_ZERO) ? nfd_pkg::ST_POST : nfd_pkg::ST_OK;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

endmodule

[rtl/core/nfd_out_buf.sv]
// ----------------------------------------------------------------------------
// nfd_out_buf
// Two-entry result buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
module nfd_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nfd_pkg::res_t push_res,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output nfd_pkg::res_t out_res
);

  logic          main_valid_r, main_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  nfd_pkg::res_t main_r, main_nxt;
  nfd_pkg::res_t skid_r, skid_nxt;

  // Pushes arrive only while the skid stage is empty.
  always_comb begin
    main_valid_nxt = main_valid_r;
    main_nxt       = main_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || out_ready) begin
      main_valid_nxt = skid_valid_r | push;
      main_nxt       = skid_valid_r ? skid_r : push_res;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

endmodule

[rtl/core/nfd_checker.sv]
// ----------------------------------------------------------------------------
// nfd_checker
// Port-level assertions for the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module nfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  // A stalled result beat stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out beat dropped while stalled");

  // Backpressure toward the input only with a result waiting at the output.
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("in_tready low with empty output register");

  // Payload beats carry status ok.
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == nfd_pkg::ST_OK)
    else $error("payload beat with nonzero status");

  // ACK and NACK frames report no payload bytes.
  a_ack_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast &&
      (out_tuser == nfd_pkg::ST_ACK || out_tuser == nfd_pkg::ST_NACK)
      |-> out_tdata == 8'd0)
    else $error("ACK or NACK with nonzero count");

  // No result leaves the block right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind nfc_frame_deframer_unit nfd_checker u_nfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[bench/nfd_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfd_frame_checker
// Watches the in_, out_ and cfg_ ports of the frame deframer, parses every
// accepted input beat with its own frame state machine, and compares each
// accepted output beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module nfd_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [2:0] out_tuser,
  input  logic       out_tlast,
  output int         fail_count,
  output int         pending_count
);

  nfd_pkg::phase_t frame_phase;
  nfd_pkg::kind_t  frame_kind;
  logic [7:0]      command_code;
  logic [7:0]      frame_len;
  logic [7:0]      running_sum;
  logic [7:0]      payload_left;
  nfd_pkg::res_t   expected_results[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Close the frame with a final item.
  task automatic close_frame(input logic [7:0] count, input nfd_pkg::status_t code,
                             output nfd_pkg::res_t r);
    r.data      = count;
    r.status    = code;
    r.last      = 1'b1;
    frame_phase = nfd_pkg::PH_DONE;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic start,
                            output logic emit, output nfd_pkg::res_t r);
    logic [7:0] len_sum;
    logic [7:0] code_want;
    emit      = 1'b0;
    r         = '0;
    len_sum   = frame_len + b;
    code_want = command_code + 8'd1;
    if (start) begin
      frame_phase  = nfd_pkg::PH_PRE0;
      frame_len    = 8'd0;
      running_sum  = 8'd0;
      payload_left = 8'd0;
      frame_kind   = nfd_pkg::KIND_NORMAL;
    end else begin
      case (frame_phase)
        nfd_pkg::PH_PRE0: begin
          if (b != nfd_pkg::BYTE_ZERO) begin
            emit = 1'b1;
            close_frame(8'd0, nfd_pkg::ST_PREAMBLE, r);
          end else frame_phase = nfd_pkg::PH_PRE1;
        end
        nfd_pkg::PH_PRE1: begin
          if (b != nfd_pkg::BYTE_ZERO) begin
            emit = 1'b1;
            close_frame(8'd0, nfd_pkg::ST_PREAMBLE, r);
          end else frame_phase = nfd_pkg::PH_START;
        end
        nfd_pkg::PH_START: begin
          if (b != nfd_pkg::BYTE_START) begin
            emit = 1'b1;
            close_frame(8'd0, nfd_pkg::ST_PREAMBLE, r);
          end else frame_phase = nfd_pkg::PH_LEN;
        end
        nfd_pkg::PH_LEN: begin
          frame_len   = b;
          frame_phase = nfd_pkg::PH_LCS;
        end
        nfd_pkg::PH_LCS: begin
          if (frame_len == nfd_pkg::BYTE_ZERO && b == nfd_pkg::BYTE_START) begin
            frame_kind  = nfd_pkg::KIND_ACK;
            frame_phase = nfd_pkg::PH_ACKPOST;
          end else if (frame_len == nfd_pkg::BYTE_START && b == nfd_pkg::BYTE_ZERO) begin
            frame_kind  = nfd_pkg::KIND_NACK;
            frame_phase = nfd_pkg::PH_ACKPOST;
          end else if (len_sum != 8'd0 || frame_len < nfd_pkg::MIN_LEN) begin
            emit = 1'b1;
            close_frame(8'd0, nfd_pkg::ST_LENGTH, r);
          end else begin
            frame_kind  = nfd_pkg::KIND_NORMAL;
            frame_phase = nfd_pkg::PH_TFI;
          end
        end
        nfd_pkg::PH_ACKPOST: begin
          emit = 1'b1;
          if (b != nfd_pkg::BYTE_ZERO) close_frame(8'd0, nfd_pkg::ST_POST, r);
          else close_frame(8'd0, (frame_kind == nfd_pkg::KIND_ACK) ? nfd_pkg::ST_ACK
                                                                   : nfd_pkg::ST_NACK, r);
        end
        nfd_pkg::PH_TFI: begin
          if (b != nfd_pkg::BYTE_TFI) begin
            emit = 1'b1;
            close_frame(8'd0, nfd_pkg::ST_MISMATCH, r);
          end else begin
            running_sum = b;
            frame_phase = nfd_pkg::PH_CODE;
          end
        end
        nfd_pkg::PH_CODE: begin
          if (b != code_want) begin
            emit = 1'b1;
            close_frame(8'd0, nfd_pkg::ST_MISMATCH, r);
          end else begin
            running_sum  = running_sum + b;
            payload_left = frame_len - nfd_pkg::MIN_LEN;
            frame_phase  = (payload_left == 8'd0) ? nfd_pkg::PH_DCS : nfd_pkg::PH_DATA;
          end
        end
        nfd_pkg::PH_DATA: begin
          running_sum  = running_sum + b;
          payload_left = payload_left - 8'd1;
          if (payload_left == 8'd0) frame_phase = nfd_pkg::PH_DCS;
          emit     = 1'b1;
          r.data   = b;
          r.status = nfd_pkg::ST_OK;
          r.last   = 1'b0;
        end
        nfd_pkg::PH_DCS: begin
          running_sum = running_sum + b;
          if (running_sum != 8'd0) begin
            emit = 1'b1;
            close_frame(frame_len - nfd_pkg::MIN_LEN, nfd_pkg::ST_DATA, r);
          end else frame_phase = nfd_pkg::PH_POST;
        end
        nfd_pkg::PH_POST: begin
          emit = 1'b1;
          close_frame(frame_len - nfd_pkg::MIN_LEN,
                      (b != nfd_pkg::BYTE_ZERO) ? nfd_pkg::ST_POST : nfd_pkg::ST_OK, r);
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    nfd_pkg::res_t want;
    nfd_pkg::res_t pred;
    logic          emit;
    if (!rst_n) begin
      frame_phase  = nfd_pkg::PH_IDLE;
      frame_kind   = nfd_pkg::KIND_NORMAL;
      command_code = 8'd0;
      frame_len    = 8'd0;
      running_sum  = 8'd0;
      payload_left = 8'd0;
      expected_results.delete();
    end else begin
      // Compare first: a result never belongs to a beat taken at the same edge.
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, got data %h status %0d last %b",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata !== want.data || out_tuser !== want.status ||
              out_tlast !== want.last) begin
            fail_count++;
            $display("%0t: result mismatch: expected data %h status %0d last %b,",
                     $time, want.data, want.status, want.last,
                     " got data %h status %0d last %b",
                     out_tdata, out_tuser, out_tlast);
          end
        end
      end
      if (cfg_wr_en) command_code = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, in_tuser, emit, pred);
        if (emit) expected_results.push_back(pred);
      end
    end
    pending_count = expected_results.size();
  end

endmodule

[bench/tb_nfc_frame_deframer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nfc_frame_deframer_unit
// Drives controller reads into the frame deframer: a few directed frames, then
// random well-formed frames with corrupted, truncated and noisy variants under
// several expected-command settings. A checker beside the block predicts and
// compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_nfc_frame_deframer_unit;

  // Watchdog: cycles in a row with no beat on either side before giving up.
  localparam int WATCHDOG_LIMIT   = 2000;
  // Result is registered in the output buffer; allow for the skid stage too.
  localparam int DRAIN_CYCLES     = 8;
  localparam int ITEMS_PER_SETTING = 120;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_SPARSE} ready_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  int fail_count;
  int pending_count;

  // Sender state
  int         burst_left;
  int         items_sent;
  logic [7:0] cur_cmd;
  logic [7:0] frame_bytes[$];

  // Receiver state
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          seg_left   = 0;
  int          period     = 2;
  int          stall_len  = 1;
  int          phase_cnt  = 0;

  int idle_cycles = 0;

  always #1 clk = ~clk;

  nfc_frame_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  nfd_frame_checker frame_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // Receiver: pick a stall pattern for a segment, then follow it. Always-ready
  // segments give stretches with no back-pressure at all.
  always @(negedge clk) begin
    if (seg_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      seg_left   = $urandom_range(20, 80);
      period     = $urandom_range(2, 10);
      stall_len  = $urandom_range(1, period - 1);
      phase_cnt  = 0;
    end
    seg_left--;
    phase_cnt = (phase_cnt + 1) % period;
    case (ready_mode)
      RDY_ALWAYS:   out_tready <= 1'b1;
      RDY_COIN:     out_tready <= 1'($urandom_range(0, 1));
      RDY_PERIODIC: out_tready <= (phase_cnt >= stall_len);
      default:      out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_nfc_frame_deframer_unit: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one beat. Called at a falling edge; returns at the falling edge after
  // the beat is accepted, with tvalid still high so back-to-back beats stay
  // back-to-back. When a burst runs out, drop tvalid for a random gap first.
  task automatic send_beat(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 20);
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Send a read: a random status byte marked as start, then the frame bytes.
  task automatic send_read();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    foreach (frame_bytes[i]) send_beat(frame_bytes[i], 1'b0);
    items_sent += 1 + frame_bytes.size();
  endtask

  // Build a well-formed information frame with n random payload bytes.
  task automatic build_frame(input int n, input logic [7:0] code);
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] p;
    frame_bytes.delete();
    len = 8'(n + 2);
    sum = nfd_pkg::BYTE_TFI + code;
    frame_bytes = '{nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_START, len,
                    8'd0 - len, nfd_pkg::BYTE_TFI, code};
    for (int i = 0; i < n; i++) begin
      p = 8'($urandom_range(0, 255));
      sum = sum + p;
      frame_bytes.push_back(p);
    end
    frame_bytes.push_back(8'd0 - sum);
    frame_bytes.push_back(nfd_pkg::BYTE_ZERO);
  endtask

  // Hold off until every result is out and the pipe is empty, then write the
  // expected command.
  task automatic set_command(input logic [7:0] c);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_cmd   = c;
  endtask

  // One random read. Mostly well-formed frames with random payload; some get a
  // corrupted byte, get cut short by the next read, or carry trailing bytes.
  task automatic random_read();
    int         pick;
    int         n;
    int         pos;
    int         cut;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      // Noise: loose bytes, sometimes with a start bit.
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      items_sent += n;
    end else begin
      if (pick < 12) begin
        frame_bytes = '{nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_START,
                        nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_START, nfd_pkg::BYTE_ZERO};
      end else if (pick < 18) begin
        frame_bytes = '{nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_START,
                        nfd_pkg::BYTE_START, nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_ZERO};
      end else if (pick < 22) begin
        // Short frame: length pair adds up, but no room for D5 and the code.
        if ($urandom_range(0, 1) == 0)
          frame_bytes = '{nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_START,
                          8'h00, 8'h00};
        else
          frame_bytes = '{nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_START,
                          8'h01, 8'hFF};
      end else begin
        n = $urandom_range(0, 99);
        if (n < 3)       n = $urandom_range(100, 253);
        else if (n < 15) n = 0;
        else             n = $urandom_range(1, 12);
        code = cur_cmd + 8'd1;
        if ($urandom_range(0, 19) == 0) code = 8'($urandom_range(0, 255));
        build_frame(n, code);
      end
      // Flip one byte somewhere after the status byte.
      if ($urandom_range(0, 99) < 30) begin
        pos = $urandom_range(0, frame_bytes.size() - 1);
        frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
      end
      // Cut the read short; the next read restarts the parser mid-frame.
      if ($urandom_range(0, 99) < 10) begin
        cut = $urandom_range(0, frame_bytes.size() - 1);
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
      // Trailing bytes after the frame should be dropped.
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_read();
    end
  endtask

  initial begin
    logic [7:0] settings[5];
    int         mark;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 8'd0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'd0;
    in_tuser    = 1'b0;
    cur_cmd     = 8'd0;
    burst_left  = 0;
    items_sent  = 0;
    settings    = '{8'hFF, 8'h00, 8'd0, 8'd0, 8'h7F};
    settings[2] = 8'($urandom_range(0, 255));
    settings[3] = 8'($urandom_range(0, 255));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: run under the reset value of the expected command.
    // Stray byte before any read: dropped.
    send_beat(8'hA5, 1'b0);
    items_sent++;
    // ACK frame.
    frame_bytes = '{nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_START,
                    nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_START, nfd_pkg::BYTE_ZERO};
    send_read();
    // Bad preamble on the first byte.
    frame_bytes = '{nfd_pkg::BYTE_START};
    send_read();
    // Short frame: zero length with a zero checksum.
    frame_bytes = '{nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_ZERO, nfd_pkg::BYTE_START,
                    8'h00, 8'h00};
    send_read();
    // Good frame with no payload.
    build_frame(0, cur_cmd + 8'd1);
    send_read();

    // Random reads under each command setting, extremes included.
    foreach (settings[k]) begin
      set_command(settings[k]);
      mark = items_sent;
      while (items_sent - mark < ITEMS_PER_SETTING) random_read();
    end

    // Drain: wait for every predicted result, then DRAIN_CYCLES more for
    // anything the block should not send.
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_nfc_frame_deframer_unit: clean");
    end else begin
      $display("tb_nfc_frame_deframer_unit: errors");
    end
    $finish;
  end

endmodule
